// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/cdb_pkg.sv -----
// ----------------------------------------------------------------------------
// cdb_pkg
// Widths and operation/status codes of the circular deque buffer.
// ----------------------------------------------------------------------------
package cdb_pkg;

  localparam int KindW   = 3;
  localparam int WordW   = 32;
  localparam int StatusW = 2;

  // operation codes
  localparam logic [KindW-1:0] KindPushFront = 3'd0;
  localparam logic [KindW-1:0] KindPushRear  = 3'd1;
  localparam logic [KindW-1:0] KindPopFront  = 3'd2;
  localparam logic [KindW-1:0] KindPopRear   = 3'd3;
  localparam logic [KindW-1:0] KindList      = 3'd4;

  // result status codes
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  typedef logic [KindW-1:0]        kind_t;
  typedef logic [StatusW-1:0]      status_t;
  typedef logic signed [WordW-1:0] word_t;

endpackage

// ----- rtl/cdb_req_if.sv -----
// ----------------------------------------------------------------------------
// cdb_req_if
// Request channel: one operation and its push word per beat.
// ----------------------------------------------------------------------------
interface cdb_req_if
  import cdb_pkg::*;
();
  logic  valid;
  logic  ready;
  kind_t kind;
  word_t value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- rtl/cdb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// cdb_rsp_if
// Response channel: status, word and end-of-item flag per beat.
// ----------------------------------------------------------------------------
interface cdb_rsp_if
  import cdb_pkg::*;
();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   data;
  logic    last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ----- rtl/circular_deque_buffer.sv -----
// Push, full and empty answers appear in the cycle after accept; unknown kinds drop.
// Pop: read state, send state, then output register to the response beat.
// List: each stored word goes through read, send and output register (one registered read port).
// A new request is taken once the sequencer is back in idle and the output
// register is free. Reset clears pointers, count and control; store contents
// stay undefined (no clearing pass, only occupied entries are ever read).
// ----------------------------------------------------------------------------
// circular_deque_buffer
// Double-ended queue in a circular store with a registered-read memory port
// shared by pops and listing under a small sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_deque_buffer
  import cdb_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdb_req_if.sink   req_i,
  cdb_rsp_if.source rsp_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StSend = 2'd2;

  function automatic logic [IW-1:0] idx_next(logic [IW-1:0] i);
    return (i == LastIdx) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_prev(logic [IW-1:0] i);
    return (i == '0) ? LastIdx : i - IW'(1);
  endfunction

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [IW-1:0] addr_q, addr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  word_t         mem_q [DEPTH];
  word_t         rdata_q;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          rd_en;

  logic          rsp_vld_q, rsp_vld_d;
  status_t       rsp_status_q;
  word_t         rsp_data_q;
  logic          rsp_last_q;
  logic          ld;
  status_t       ld_status;
  word_t         ld_data;
  logic          ld_last;

  logic          rsp_free;
  logic          req_fire;
  logic          is_empty;
  logic          is_full;
  logic [CW-1:0] span;

  assign rsp_free    = !rsp_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == StIdle) && rsp_free;
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_empty    = (occ_q == '0);
  assign is_full     = (occ_q == FullCnt);

  assign rsp_o.valid  = rsp_vld_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.data   = rsp_data_q;
  assign rsp_o.last   = rsp_last_q;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    occ_d     = occ_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    wr_en     = 1'b0;
    wr_addr   = '0;
    rd_en     = 1'b0;
    ld        = 1'b0;
    ld_status = StatusOk;
    ld_data   = '0;
    ld_last   = 1'b1;

    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          case (req_i.kind) inside
            KindPushFront, KindPushRear: begin
              ld = 1'b1;
              if (is_full) begin
                ld_status = StatusFull;
              end else begin
                wr_en = 1'b1;
                occ_d = occ_q + CW'(1);
                if (is_empty) begin
                  head_d  = '0;
                  tail_d  = '0;
                  wr_addr = '0;
                end else if (req_i.kind == KindPushFront) begin
                  head_d  = idx_prev(head_q);
                  wr_addr = idx_prev(head_q);
                end else begin
                  tail_d  = idx_next(tail_q);
                  wr_addr = idx_next(tail_q);
                end
              end
            end
            KindPopFront, KindPopRear: begin
              if (is_empty) begin
                ld        = 1'b1;
                ld_status = StatusEmpty;
              end else begin
                cnt_d   = CW'(1);
                occ_d   = occ_q - CW'(1);
                state_d = StRead;
                if (req_i.kind == KindPopFront) begin
                  addr_d = head_q;
                  head_d = idx_next(head_q);
                end else begin
                  addr_d = tail_q;
                  tail_d = idx_prev(tail_q);
                end
                // last word gone: pointers go home
                if (occ_q == CW'(1)) begin
                  head_d = '0;
                  tail_d = '0;
                end
              end
            end
            KindList: begin
              if (is_empty) begin
                ld        = 1'b1;
                ld_status = StatusEmpty;
              end else begin
                addr_d  = head_q;
                cnt_d   = occ_q;
                state_d = StRead;
              end
            end
            default: ;
          endcase
        end
      end
      StRead: begin
        rd_en   = 1'b1;
        state_d = StSend;
      end
      StSend: begin
        if (rsp_free) begin
          ld      = 1'b1;
          ld_data = rdata_q;
          ld_last = (cnt_q == CW'(1));
          cnt_d   = cnt_q - CW'(1);
          addr_d  = idx_next(addr_q);
          state_d = (cnt_q == CW'(1)) ? StIdle : StRead;
        end
      end
      default: state_d = StIdle;
    endcase

    rsp_vld_d = ld || (rsp_vld_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      tail_q    <= '0;
      occ_q     <= '0;
      addr_q    <= '0;
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      occ_q     <= occ_d;
      addr_q    <= addr_d;
      cnt_q     <= cnt_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      rsp_status_q <= ld_status;
      rsp_data_q   <= ld_data;
      rsp_last_q   <= ld_last;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= req_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  // distance from head to tail around the ring; wraps harmlessly in CW bits
  assign span = (tail_q >= head_q) ? (CW'(tail_q) - CW'(head_q))
                                   : (CW'(tail_q) + FullCnt - CW'(head_q));

  `ASSERT_IMPLY(a_occ_range, clk_i, rst_ni, 1'b1, occ_q <= FullCnt)
  `ASSERT_IMPLY(a_empty_home, clk_i, rst_ni, is_empty, (head_q == '0) && (tail_q == '0))
  `ASSERT_IMPLY(a_span_occ, clk_i, rst_ni, !is_empty, span == (occ_q - CW'(1)))
  `ASSERT_NEXT(a_busy_blocks, clk_i, rst_ni, state_q == StRead, !req_i.ready)

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular deque buffer. A short directed table
// covers empty, full and wrap cases, then weighted random operations run
// against an in-bench deque model under changing valid/ready idling.
// ----------------------------------------------------------------------------
module tb_top;
  import cdb_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int RandomOps  = 330;
  localparam int CycleLimit = 600_000;

  // kinds the block must drop without a response
  localparam kind_t KindSpareLo = 3'd5;
  localparam kind_t KindSpareHi = 3'd7;

  typedef struct packed {
    status_t status;
    word_t   data;
    logic    last;
  } rsp_beat_t;

  typedef struct packed {
    kind_t    kind;
    word_t    value;
    logic [4:0] reps;
    logic     typed;
    status_t  status;
    word_t    data;
    logic     last;
  } dir_row_t;

  // Repeated rows push value, value+1, ...; typed rows carry their own answer.
  localparam dir_row_t DirRows [16] = '{
    '{KindPopFront,  32'h0000_0000, 5'd1, 1'b1, StatusEmpty, 32'h0, 1'b1},
    '{KindPopRear,   32'h0000_0000, 5'd1, 1'b1, StatusEmpty, 32'h0, 1'b1},
    '{KindList,      32'h0000_0000, 5'd1, 1'b1, StatusEmpty, 32'h0, 1'b1},
    '{KindSpareHi,   32'hFFFF_FFFF, 5'd1, 1'b0, StatusOk,    32'h0, 1'b0},
    '{KindPushRear,  32'h7FFF_FFFF, 5'd1, 1'b1, StatusOk,    32'h0, 1'b1},
    '{KindPopFront,  32'h0000_0000, 5'd1, 1'b0, StatusOk,    32'h0, 1'b0},
    '{KindPushFront, 32'h8000_0000, 5'd1, 1'b1, StatusOk,    32'h0, 1'b1},
    '{KindPushFront, 32'h5A5A_0000, 5'd7, 1'b0, StatusOk,    32'h0, 1'b0},
    '{KindPushRear,  32'hA5A5_0000, 5'd8, 1'b0, StatusOk,    32'h0, 1'b0},
    '{KindPushRear,  32'h0000_0001, 5'd1, 1'b1, StatusFull,  32'h0, 1'b1},
    '{KindPushFront, 32'hFFFF_FFFF, 5'd1, 1'b1, StatusFull,  32'h0, 1'b1},
    '{KindList,      32'h0000_0000, 5'd1, 1'b0, StatusOk,    32'h0, 1'b0},
    '{KindPopRear,   32'h0000_0000, 5'd1, 1'b0, StatusOk,    32'h0, 1'b0},
    '{KindPopFront,  32'h0000_0000, 5'd1, 1'b0, StatusOk,    32'h0, 1'b0},
    '{KindSpareLo,   32'h1234_5678, 5'd1, 1'b0, StatusOk,    32'h0, 1'b0},
    '{KindList,      32'h0000_0000, 5'd1, 1'b0, StatusOk,    32'h0, 1'b0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  cdb_req_if req_bus ();
  cdb_rsp_if rsp_bus ();

  circular_deque_buffer #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  word_t     deque_words [$];
  rsp_beat_t pending_beats [$];
  rsp_beat_t step_beats [$];
  rsp_beat_t exp_beat;

  int src_idle_pct = 36;
  int snk_idle_pct = 61;
  int fail_count    = 0;
  int beats_checked = 0;
  int ops_sent      = 0;
  int list_ops      = 0;
  int full_refusals = 0;
  int empty_answers = 0;
  int ignored_ops   = 0;
  int cycle_count   = 0;

  // Deque model: fills step_beats with the beats one operation should produce.
  function automatic void model_step(kind_t k, word_t v);
    word_t popped;
    step_beats.delete();
    case (k)
      KindPushFront, KindPushRear: begin
        if (deque_words.size() >= DEPTH) begin
          step_beats.push_back('{status: StatusFull, data: 0, last: 1'b1});
          full_refusals++;
        end else begin
          if (k == KindPushFront) deque_words.push_front(v);
          else deque_words.push_back(v);
          step_beats.push_back('{status: StatusOk, data: 0, last: 1'b1});
        end
      end
      KindPopFront, KindPopRear: begin
        if (deque_words.size() == 0) begin
          step_beats.push_back('{status: StatusEmpty, data: 0, last: 1'b1});
          empty_answers++;
        end else begin
          if (k == KindPopFront) popped = deque_words.pop_front();
          else popped = deque_words.pop_back();
          step_beats.push_back('{status: StatusOk, data: popped, last: 1'b1});
        end
      end
      KindList: begin
        list_ops++;
        if (deque_words.size() == 0) begin
          step_beats.push_back('{status: StatusEmpty, data: 0, last: 1'b1});
          empty_answers++;
        end else begin
          foreach (deque_words[i])
            step_beats.push_back('{status: StatusOk, data: deque_words[i],
                                   last: (i == deque_words.size() - 1)});
        end
      end
      default: ignored_ops++;
    endcase
  endfunction

  task automatic send_op(kind_t k, word_t v, bit typed, rsp_beat_t typed_beat);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.kind  <= k;
    req_bus.value <= v;
    do @(posedge clk_i); while (!req_bus.ready);
    model_step(k, v);
    if (typed) pending_beats.push_back(typed_beat);
    else foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    ops_sent++;
  endtask

  // hold off the request side until every expected beat has drained
  task automatic wait_quiet();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rsp_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: status=%0d data=%0d last=%0b",
               rsp_bus.status, rsp_bus.data, rsp_bus.last);
        fail_count++;
      end else begin
        exp_beat = pending_beats.pop_front();
        beats_checked++;
        if (rsp_bus.status !== exp_beat.status) begin
          $error("status: expected %0d, got %0d", exp_beat.status, rsp_bus.status);
          fail_count++;
        end
        if (rsp_bus.data !== exp_beat.data) begin
          $error("data: expected %0d, got %0d", exp_beat.data, rsp_bus.data);
          fail_count++;
        end
        if (rsp_bus.last !== exp_beat.last) begin
          $error("last: expected %0b, got %0b", exp_beat.last, rsp_bus.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_count, pending_beats.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int        good_ops;
    int        phase;
    int        r;
    int        push_bias;
    kind_t     k;
    word_t     v;
    rsp_beat_t row_beat;

    req_bus.valid = 1'b0;
    req_bus.kind  = KindPushFront;
    req_bus.value = '0;
    rsp_bus.ready = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      row_beat = '{status: DirRows[i].status, data: DirRows[i].data, last: DirRows[i].last};
      for (int n = 0; n < DirRows[i].reps; n++)
        send_op(DirRows[i].kind, DirRows[i].value + n, DirRows[i].typed, row_beat);
    end

    good_ops  = 0;
    phase     = 0;
    push_bias = 50;
    while (good_ops < RandomOps) begin
      if (good_ops * 3 / RandomOps != phase) begin
        wait_quiet();
        phase = good_ops * 3 / RandomOps;
        src_idle_pct = (phase == 1) ? 61 : 0;
        snk_idle_pct = (phase == 1) ? 36 : 0;
      end
      // swing between filling and draining so both full and empty get hit
      if ($urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 2))
          0:       push_bias = 85;
          1:       push_bias = 50;
          default: push_bias = 15;
        endcase
      end

      v = $urandom;
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       v = 32'h0000_0000;
          1:       v = 32'hFFFF_FFFF;
          2:       v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end

      r = $urandom_range(0, 99);
      if (r < 3) k = kind_t'($urandom_range(KindSpareLo, KindSpareHi));
      else if (r < 13) k = KindList;
      else if ($urandom_range(0, 99) < push_bias)
        k = $urandom_range(0, 1) ? KindPushRear : KindPushFront;
      else
        k = $urandom_range(0, 1) ? KindPopRear : KindPopFront;

      send_op(k, v, 1'b0, '0);
      if (k <= KindList) good_ops++;
    end

    wait_quiet();
    repeat (40) @(posedge clk_i);

    $display("%0d operations sent (%0d lists, %0d dropped kinds), %0d beats checked",
             ops_sent, list_ops, ignored_ops, beats_checked);
    $display("%0d refused pushes, %0d empty answers, %0d mismatches",
             full_refusals, empty_answers, fail_count);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
